// File: src/decimal_string_to_signed_integer_assert.svh
// assertion macros for the decimal string converter
// expects signals named clock and reset in the scope of use
`ifndef DECIMAL_STRING_TO_SIGNED_INTEGER_ASSERT_SVH
`define DECIMAL_STRING_TO_SIGNED_INTEGER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DSTOI_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define DSTOI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/dstoi_pkg.sv
// shared types and constants for the decimal string converter
// no dependencies
`default_nettype none

package dstoi_pkg;

   localparam int CharWidth   = 21;
   localparam int CountWidth  = 5;
   localparam int OutWidth    = 64;
   localparam int StatusWidth = 2;

   localparam logic [CharWidth-1:0] CharMinus = 21'h00002D;
   localparam logic [CharWidth-1:0] CharZero  = 21'h000030;
   localparam logic [CharWidth-1:0] CharNine  = 21'h000039;

   localparam logic [StatusWidth-1:0] StatusOk     = 2'd0;
   localparam logic [StatusWidth-1:0] StatusNotInt = 2'd1;
   localparam logic [StatusWidth-1:0] StatusRange  = 2'd2;

   // per-string parse flags
   typedef struct packed {
      logic                  at_start;
      logic                  negative;
      logic                  pending_zero;
      logic                  saw_nondigit;
      logic                  overflowed;
      logic [CountWidth-1:0] sig_count;
   } dstoi_flags_type;

   localparam dstoi_flags_type FlagsReset = '{
      at_start:     1'b1,
      negative:     1'b0,
      pending_zero: 1'b0,
      saw_nondigit: 1'b0,
      overflowed:   1'b0,
      sig_count:    '0
   };

endpackage

`default_nettype wire

// File: src/dstoi_step.sv
// one character of the parse: state update and end-of-string result
// depends on dstoi_pkg
`default_nettype none

module dstoi_step import dstoi_pkg::*; #(
   parameter int VALUE_WIDTH = 64,
   parameter int MAX_DIGITS  = 19
) (
   input  wire  dstoi_flags_type         flags_cur,
   input  wire  logic [VALUE_WIDTH-1:0]  mag_cur,
   input  wire  logic [CharWidth-1:0]    char_code,
   input  wire  logic                    is_last,
   input  wire  logic                    is_empty,
   output dstoi_flags_type               flags_next,
   output logic [VALUE_WIDTH-1:0]        mag_next,
   output logic                          has_result,
   output logic signed [OutWidth-1:0]    value,
   output logic [StatusWidth-1:0]        status
);

   localparam int ProdWidth = VALUE_WIDTH + 4;

   dstoi_flags_type               taken;
   logic [VALUE_WIDTH-1:0]        mag_taken;
   logic                          is_sign;
   logic                          is_lead_zero;
   logic                          is_digit;
   logic [ProdWidth-1:0]          mag_ext;
   logic [ProdWidth-1:0]          prod;
   logic [ProdWidth-1:0]          limit;
   logic signed [VALUE_WIDTH-1:0] value_w;

   // character classes
   assign is_sign      = flags_cur.at_start && (char_code == CharMinus);
   assign is_lead_zero = !is_sign && (flags_cur.sig_count == '0) && (char_code == CharZero);
   assign is_digit     = (char_code >= CharZero) && (char_code <= CharNine);

   // magnitude*10 + digit; low nibble of an ascii digit is its value
   assign mag_ext = ProdWidth'(mag_cur);
   assign prod    = (mag_ext << 3) + (mag_ext << 1) + ProdWidth'(char_code[3:0]);

   // limit is 2^(w-1) for negative, 2^(w-1)-1 otherwise
   assign limit = {4'b0000, flags_cur.negative, {(VALUE_WIDTH-1){~flags_cur.negative}}};

   // take the character into the state
   always_comb begin
      taken          = flags_cur;
      mag_taken      = mag_cur;
      taken.at_start = 1'b0;
      if (is_sign) begin
         taken.negative = 1'b1;
      end else if (is_lead_zero) begin
         taken.pending_zero = 1'b1;
      end else begin
         if (flags_cur.sig_count <= CountWidth'(MAX_DIGITS)) begin
            taken.sig_count = flags_cur.sig_count + 1'b1;
         end
         if (!is_digit) begin
            taken.saw_nondigit = 1'b1;
         end else if (!flags_cur.overflowed) begin
            if (prod > limit) begin
               taken.overflowed = 1'b1;
            end else begin
               mag_taken = prod[VALUE_WIDTH-1:0];
            end
         end
      end
   end

   // signed value of the finished magnitude
   assign value_w = taken.negative ? signed'(~mag_taken + 1'b1) : signed'(mag_taken);

   // end of string checks, in priority order
   always_comb begin
      has_result = is_empty || is_last;
      value      = '0;
      flags_next = taken;
      mag_next   = mag_taken;
      if (has_result) begin
         flags_next = FlagsReset;
         mag_next   = '0;
      end
      priority if (is_empty) begin
         status = StatusNotInt;
      end else if ((taken.sig_count == '0) && !taken.pending_zero) begin
         status = StatusNotInt;
      end else if (taken.sig_count > CountWidth'(MAX_DIGITS)) begin
         status = StatusRange;
      end else if (taken.saw_nondigit) begin
         status = StatusNotInt;
      end else if (taken.overflowed) begin
         status = StatusRange;
      end else begin
         status = StatusOk;
         value  = OutWidth'(value_w);
      end
   end

endmodule

`default_nettype wire

// File: src/decimal_string_to_signed_integer.sv
// decimal string to signed integer converter, top level
// depends on dstoi_pkg, dstoi_step and the assertion macro header
//
// The req channel carries one character per beat (req_char_code, with
// req_is_last on the final character); a beat with req_is_empty ends an
// empty string. The rsp channel gives one beat per finished string:
// rsp_value (sign-extended) and rsp_status (0 ok, 1 not an integer,
// 2 out of range); rsp_value is zero on any error.
// A beat taken on req is held in the input register; the character
// step (multiply by ten, add, compare) then runs from it and, at the
// end of a string, loads the result register once that is free. One
// character per cycle is sustained while the receiver does not stall.
// While the receiver stalls, the result register holds and the input
// register keeps one more beat; req_ready drops only when both are full.
// Synchronous reset empties both registers and starts a new string.
`default_nettype none

`include "decimal_string_to_signed_integer_assert.svh"

module decimal_string_to_signed_integer import dstoi_pkg::*; #(
   parameter int VALUE_WIDTH = 64,
   parameter int MAX_DIGITS  = 19
) (
   input  wire  logic                     clock,
   input  wire  logic                     reset,
   input  wire  logic                     req_valid,
   output logic                           req_ready,
   input  wire  logic [CharWidth-1:0]     req_char_code,
   input  wire  logic                     req_is_last,
   input  wire  logic                     req_is_empty,
   output logic                           rsp_valid,
   input  wire  logic                     rsp_ready,
   output logic signed [OutWidth-1:0]     rsp_value,
   output logic [StatusWidth-1:0]         rsp_status
);

   logic                       in_valid_ff;
   logic [CharWidth-1:0]       char_ff;
   logic                       last_ff;
   logic                       empty_ff;
   dstoi_flags_type            flags_ff;
   dstoi_flags_type            flags_in;
   logic [VALUE_WIDTH-1:0]     mag_ff;
   logic [VALUE_WIDTH-1:0]     mag_in;
   logic                       rsp_valid_ff;
   logic signed [OutWidth-1:0] value_ff;
   logic signed [OutWidth-1:0] value_in;
   logic [StatusWidth-1:0]     status_ff;
   logic [StatusWidth-1:0]     status_in;
   logic                       has_result;
   logic                       out_free;
   logic                       advance;

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         char_ff  <= req_char_code;
         last_ff  <= req_is_last;
         empty_ff <= req_is_empty;
      end
   end

   // character step
   dstoi_step #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_step (
      .flags_cur  (flags_ff),
      .mag_cur    (mag_ff),
      .char_code  (char_ff),
      .is_last    (last_ff),
      .is_empty   (empty_ff),
      .flags_next (flags_in),
      .mag_next   (mag_in),
      .has_result (has_result),
      .value      (value_in),
      .status     (status_in)
   );

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= FlagsReset;
         mag_ff   <= '0;
      end else if (advance) begin
         flags_ff <= flags_in;
         mag_ff   <= mag_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && has_result) begin
         value_ff  <= value_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;

   // checks
   `DSTOI_ASSERT_NOW(a_err_value_zero, rsp_valid_ff && (status_ff != StatusOk), value_ff == '0, "error result with nonzero value")
   `DSTOI_ASSERT_NEXT(a_empty_not_int, advance && empty_ff, rsp_valid_ff && (status_ff == StatusNotInt), "empty string did not give not-an-integer")
   `DSTOI_ASSERT_NEXT(a_restart_after_result, advance && (last_ff || empty_ff), flags_ff.at_start && (mag_ff == '0), "state not cleared after a result")

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// self-checking testbench for the decimal string to signed integer converter
// depends on dstoi_pkg and decimal_string_to_signed_integer; each result is
// predicted from the character beats the converter accepts
module tb_top;
   import dstoi_pkg::*;

   localparam int VALUE_WIDTH   = 64;
   localparam int MAX_DIGITS    = 19;
   localparam int RANDOM_BEATS  = 1800;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 16;

   localparam logic [CharWidth-1:0] CharPlus  = 21'h00002B;
   localparam logic [CharWidth-1:0] CharSpace = 21'h000020;
   localparam logic [CharWidth-1:0] CharTop   = {CharWidth{1'b1}};
   localparam logic [OutWidth-1:0]  Radix     = 64'd10;

   typedef struct {
      logic [CharWidth-1:0] code;
      logic                 last;
      logic                 empty;
      int unsigned          gap;
      bit                   drain;
   } char_beat_type;

   typedef struct {
      logic [OutWidth-1:0]    value;
      logic [StatusWidth-1:0] status;
   } conversion_type;

   logic                          clock         = 1'b0;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_ready;
   logic [CharWidth-1:0]          req_char_code = '0;
   logic                          req_is_last   = 1'b0;
   logic                          req_is_empty  = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready     = 1'b0;
   logic signed [OutWidth-1:0]    rsp_value;
   logic [StatusWidth-1:0]        rsp_status;

   char_beat_type        beats_to_send[$];
   conversion_type       conversions_due[$];
   logic [CharWidth-1:0] text_q[$];

   // stimulus shaping
   bit          gapped     = 1'b1;
   bit          drain_next = 1'b0;
   int unsigned beats_built = 0;

   // string state of the predictor
   bit                  str_fresh;
   bit                  str_neg;
   logic [OutWidth-1:0] str_mag;
   int unsigned         str_count;
   bit                  str_zeros;
   bit                  str_bad;
   bit                  str_over;

   // bookkeeping
   int unsigned mismatches   = 0;
   int unsigned beats_taken  = 0;
   int unsigned results_seen = 0;
   int unsigned strings_ok   = 0;
   int unsigned strings_nan  = 0;
   int unsigned strings_big  = 0;

   // driver and monitor working variables
   char_beat_type  beat_now;
   int unsigned    gap_left;
   conversion_type want;
   int unsigned    stall_left;
   int unsigned    calm_left;
   int unsigned    roll;
   logic           ready_next;
   int unsigned    idle_cycles = 0;

   decimal_string_to_signed_integer #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .req_is_empty  (req_is_empty),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status)
   );

   initial forever #2 clock = ~clock;

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   // ---------------------------------------------------------------- predictor

   task automatic restart_string();
      str_fresh = 1'b1;
      str_neg   = 1'b0;
      str_mag   = '0;
      str_count = 0;
      str_zeros = 1'b0;
      str_bad   = 1'b0;
      str_over  = 1'b0;
   endtask

   // decide the result of the string that just ended, in check order
   task automatic finish_string();
      conversion_type r;
      r.value = '0;
      if (str_count == 0 && !str_zeros) r.status = StatusNotInt;
      else if (str_count > MAX_DIGITS)  r.status = StatusRange;
      else if (str_bad)                 r.status = StatusNotInt;
      else if (str_over)                r.status = StatusRange;
      else begin
         r.status = StatusOk;
         r.value  = str_neg ? -str_mag : str_mag;
      end
      case (r.status)
         StatusOk:     strings_ok++;
         StatusNotInt: strings_nan++;
         default:      strings_big++;
      endcase
      conversions_due.push_back(r);
      restart_string();
   endtask

   task automatic convert_beat(input char_beat_type b);
      bit                  opening;
      logic [OutWidth-1:0] d;
      logic [OutWidth-1:0] lim;
      if (b.empty) begin
         // an empty mark drops whatever was partly received
         restart_string();
         finish_string();
      end else begin
         opening   = str_fresh;
         str_fresh = 1'b0;
         if (opening && b.code == CharMinus) begin
            str_neg = 1'b1;
         end else if (str_count == 0 && b.code == CharZero) begin
            str_zeros = 1'b1;
         end else begin
            if (str_count <= MAX_DIGITS) str_count++;
            if (b.code < CharZero || b.code > CharNine) begin
               str_bad = 1'b1;
            end else if (!str_over) begin
               d   = OutWidth'(b.code - CharZero);
               lim = '0;
               lim[VALUE_WIDTH-1] = 1'b1;
               if (!str_neg) lim = lim - 64'd1;
               if (str_mag > (lim - d) / Radix) str_over = 1'b1;
               else str_mag = str_mag * Radix + d;
            end
         end
         if (b.last) finish_string();
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (!gapped || r < 65) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(25, 6);
   endfunction

   function automatic logic [CharWidth-1:0] digit_char(input int unsigned lo);
      logic [CharWidth-1:0] d;
      d = CharWidth'($urandom_range(9, lo));
      return CharZero + d;
   endfunction

   function automatic logic [CharWidth-1:0] junk_char();
      case ($urandom_range(6))
         0: return CharMinus;
         1: return CharPlus;
         2: return CharSpace;
         3: return CharZero - 21'd1;
         4: return CharNine + 21'd1;
         // digit in the low byte but upper bits set
         5: return CharZero | (CharWidth'(1) << $urandom_range(CharWidth - 1, 8));
         default: return CharWidth'($urandom);
      endcase
   endfunction

   task automatic put_beat(input logic [CharWidth-1:0] code, input logic last,
                           input logic empty);
      char_beat_type b;
      b.code  = code;
      b.last  = last;
      b.empty = empty;
      b.gap   = pick_gap();
      b.drain = drain_next;
      drain_next = 1'b0;
      beats_to_send.push_back(b);
      beats_built++;
   endtask

   // move the text into beats; closed marks the final character as last
   task automatic emit_text(input bit closed);
      logic [CharWidth-1:0] c;
      while (text_q.size() > 0) begin
         c = text_q.pop_front();
         put_beat(c, closed && (text_q.size() == 0), 1'b0);
      end
   endtask

   task automatic add_literal(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back({13'd0, s[i]});
   endtask

   // optional sign and a few leading zeros
   task automatic add_prefix();
      if ($urandom_range(1)) text_q.push_back(CharMinus);
      if ($urandom_range(3) == 0) repeat ($urandom_range(3, 1)) text_q.push_back(CharZero);
   endtask

   task automatic add_number(input int unsigned n);
      text_q.push_back(digit_char(1));
      repeat (n - 1) text_q.push_back(digit_char(0));
   endtask

   initial begin
      int unsigned start;
      int unsigned n;
      bit          neg;

      restart_string();

      // directed: lone zero, sign with leading zeros, empty, bare minus, late minus
      add_literal("0");
      emit_text(1'b1);
      add_literal("-007");
      emit_text(1'b1);
      put_beat(CharWidth'($urandom), 1'b0, 1'b1);
      add_literal("-");
      emit_text(1'b1);
      add_literal("5-");
      emit_text(1'b1);
      // empty mark in mid-string
      add_literal("1");
      emit_text(1'b0);
      put_beat(CharTop, 1'b1, 1'b1);
      // twenty significant characters, code extremes among them: too long wins
      text_q.push_back('0);
      repeat (18) text_q.push_back(CharZero + 21'd1);
      text_q.push_back(CharTop);
      emit_text(1'b1);

      // random strings; open with a pause until the directed results are in
      drain_next = 1'b1;
      start = beats_built;
      while (beats_built - start < RANDOM_BEATS) begin
         if ($urandom_range(24) == 0) gapped = !gapped;
         if ($urandom_range(49) == 0) drain_next = 1'b1;
         case ($urandom_range(99)) inside
            [0:44]: begin
               // well-formed number, mostly short
               add_prefix();
               n = ($urandom_range(9) < 7) ? $urandom_range(6, 1) : $urandom_range(19, 7);
               add_number(n);
               emit_text(1'b1);
            end
            [45:59]: begin
               // nineteen digits around the signed limit
               neg = 1'($urandom_range(1));
               if (neg) text_q.push_back(CharMinus);
               if ($urandom_range(3) == 0) text_q.push_back(CharZero);
               add_literal("92233720368547758");
               case ($urandom_range(3))
                  0: begin
                     text_q.push_back(CharZero);
                     text_q.push_back(neg ? CharZero + 21'd8 : CharZero + 21'd7);
                  end
                  1: begin
                     text_q.push_back(CharZero);
                     text_q.push_back(neg ? CharNine : CharZero + 21'd8);
                  end
                  default: begin
                     text_q.push_back(digit_char(0));
                     text_q.push_back(digit_char(0));
                  end
               endcase
               emit_text(1'b1);
            end
            [60:66]: begin
               // too many significant characters, sometimes with junk
               add_prefix();
               add_number($urandom_range(23, 20));
               if ($urandom_range(2) == 0)
                  text_q[$urandom_range(text_q.size() - 1)] = junk_char();
               emit_text(1'b1);
            end
            [67:78]: begin
               // number with one broken character
               add_prefix();
               add_number($urandom_range(8, 1));
               text_q[$urandom_range(text_q.size() - 1)] = junk_char();
               emit_text(1'b1);
            end
            [79:85]: begin
               put_beat(CharWidth'($urandom), 1'($urandom_range(1)), 1'b1);
            end
            [86:90]: begin
               // partial string cut short by an empty mark
               add_prefix();
               repeat ($urandom_range(4, 1)) text_q.push_back(digit_char(0));
               emit_text(1'b0);
               put_beat(CharWidth'($urandom), 1'($urandom_range(1)), 1'b1);
            end
            [91:95]: begin
               // zeros only
               if ($urandom_range(1)) text_q.push_back(CharMinus);
               repeat ($urandom_range(4, 1)) text_q.push_back(CharZero);
               emit_text(1'b1);
            end
            default: begin
               case ($urandom_range(2))
                  0: text_q.push_back(CharMinus);
                  1: begin
                     text_q.push_back(CharMinus);
                     text_q.push_back(CharMinus);
                  end
                  default: repeat ($urandom_range(4, 1)) text_q.push_back(CharWidth'($urandom));
               endcase
               emit_text(1'b1);
            end
         endcase
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // drain, then give the converter time to show any stray result
      while (beats_taken < beats_built || conversions_due.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (conversions_due.size() > 0)
         flag_mismatch($sformatf("%0d results never arrived", conversions_due.size()));

      $display("%0d character beats, %0d strings checked", beats_taken, results_seen);
      $display("strings by status: %0d ok, %0d not an integer, %0d out of range",
               strings_ok, strings_nan, strings_big);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAILURE");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         // predict on every accepted beat
         if (req_valid && req_ready) begin
            convert_beat(beat_now);
            beats_taken++;
         end
         if (req_valid && !req_ready) begin
            // hold the beat until it is taken
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (beats_to_send.size() > 0 &&
                      !(beats_to_send[0].drain && conversions_due.size() > 0)) begin
            beat_now = beats_to_send.pop_front();
            gap_left = beat_now.gap;
            req_valid     <= 1'b1;
            req_char_code <= beat_now.code;
            req_is_last   <= beat_now.last;
            req_is_empty  <= beat_now.empty;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
         calm_left  = 0;
      end else begin
         // compare each result beat with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (conversions_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected result: value %0d status %0d",
                                       rsp_value, rsp_status));
            end else begin
               want = conversions_due.pop_front();
               results_seen++;
               if (rsp_status !== want.status)
                  flag_mismatch($sformatf("string %0d: status %0d, expected %0d",
                                          results_seen, rsp_status, want.status));
               if (rsp_value !== want.value)
                  flag_mismatch($sformatf("string %0d: value %0d, expected %0d",
                                          results_seen, rsp_value, $signed(want.value)));
            end
         end
         // receiver stalls: mostly short, a few long, some calm stretches
         if (calm_left > 0) begin
            calm_left--;
            ready_next = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else begin
            roll = $urandom_range(999);
            if (roll < 5) begin
               calm_left  = $urandom_range(400, 150);
               ready_next = 1'b1;
            end else if (roll < 600) begin
               ready_next = 1'b1;
            end else if (roll < 950) begin
               stall_left = $urandom_range(2);
               ready_next = 1'b0;
            end else begin
               stall_left = $urandom_range(30, 8);
               ready_next = 1'b0;
            end
         end
         rsp_ready <= ready_next;
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("no beat on either channel for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

endmodule

// File: files.f
+incdir+src
src/dstoi_pkg.sv
src/dstoi_step.sv
src/decimal_string_to_signed_integer.sv
dv/tb_top.sv
